/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the head-shake recenter detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/hsrd_pkg.sv */
// Types, constants and codes shared by the head-shake recenter detector modules.
package hsrd_pkg;

    localparam int AVG_FRACTION_BITS = 16;
    localparam int FILTER_GAIN       = 655;
    localparam int GAIN_SHIFT        = 16;
    localparam int YAW_PLUS_W        = 18;
    localparam int AVG_W             = YAW_PLUS_W + AVG_FRACTION_BITS;
    localparam int SUM_W             = AVG_W + GAIN_SHIFT + 1;
    localparam int KEEP_GAIN         = (1 << GAIN_SHIFT) - FILTER_GAIN;
    localparam int ROUND_HALF        = 1 << (GAIN_SHIFT - 1);

    typedef logic [YAW_PLUS_W-1:0] t_yaw_plus;
    typedef logic [AVG_W-1:0]      t_avg;
    typedef logic [SUM_W-1:0]      t_sum;

    localparam logic signed [16:0] ANGLE_MIN  = 17'h10000;
    localparam logic signed [16:0] ANGLE_MAX  = 17'h0FFFF;
    localparam t_yaw_plus          YAW_BIAS   = 18'd92160;
    localparam logic [15:0]        MIN_PACKET = 16'd12;

    localparam logic        IMU_ENABLED_RST        = 1'b0;
    localparam logic [15:0] SWING_THRESHOLD_RST    = 16'd512;
    localparam logic [15:0] TIMEOUT_MS_RST         = 16'd3000;
    localparam logic [3:0]  SWINGS_TO_RECENTER_RST = 4'd4;
    localparam logic [7:0]  STARTUP_SKIP_RST       = 8'd20;
    localparam logic [7:0]  RECENTER_SKIP_RST      = 8'd30;

    typedef enum logic [2:0] {
        CFG_IMU_ENABLED        = 3'd0,
        CFG_SWING_THRESHOLD    = 3'd1,
        CFG_TIMEOUT_MS         = 3'd2,
        CFG_SWINGS_TO_RECENTER = 3'd3,
        CFG_STARTUP_SKIP       = 3'd4,
        CFG_RECENTER_SKIP      = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_DROPPED = 2'd0,
        ST_SKIPPED = 2'd1,
        ST_TRACKED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd2
    } t_dir;

endpackage

/* rtl/head_shake_recenter_detector_core.sv */
// Head-shake recenter detector: one orientation sample in, one status result out per
// transaction. A sample is taken into an input register, and from there the whole
// update (drop and warm-up checks, offset capture, swing window timeout, swing
// detection, recenter and the low-pass yaw filter) runs in one pass and lands in
// the result register together with the new detector state. The block takes one
// sample every cycle while o_stall is low; a sample waits in the input register
// and its result in the result register, and the state loop through the filter
// multiply sets the clock rate. A held result stalls the input only when the input
// register is also full. Configuration writes take effect at once; startup_skip only
// sets the warm-up count that reset loads, which is its reset value.
`include "assert_macros.svh"

module head_shake_recenter_detector_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [16:0] i_roll_angle,
    input  logic signed [16:0] i_pitch_angle,
    input  logic signed [16:0] i_yaw_angle,
    input  logic [15:0]        i_packet_length,
    input  logic [31:0]        i_time_ms,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [16:0] o_roll_out,
    output logic signed [16:0] o_pitch_out,
    output logic signed [16:0] o_yaw_out,
    output logic signed [16:0] o_roll_offset_out,
    output logic signed [16:0] o_pitch_offset_out,
    output logic signed [16:0] o_yaw_offset_out,
    output logic               o_offsets_valid,
    output logic [3:0]         o_swing_count,
    output logic               o_recentered,
    output logic [17:0]        o_average_yaw_out
);

    logic        r_imu_enabled;
    logic [15:0] r_swing_threshold;
    logic [15:0] r_timeout_ms;
    logic [3:0]  r_swings_to_recenter;
    logic [7:0]  r_recenter_skip;

    logic               r_in_valid;
    logic signed [16:0] r_in_roll;
    logic signed [16:0] r_in_pitch;
    logic signed [16:0] r_in_yaw;
    logic [15:0]        r_in_len;
    logic [31:0]        r_in_time;

    hsrd_pkg::t_avg        r_avg;
    hsrd_pkg::t_yaw_plus   r_ref;
    hsrd_pkg::t_dir        r_dir;
    logic [3:0]            r_swings;
    logic [31:0]           r_wstart;
    logic [7:0]            r_warm;
    logic                  r_have;
    logic signed [16:0]    r_off_roll;
    logic signed [16:0]    r_off_pitch;
    logic signed [16:0]    r_off_yaw;

    hsrd_pkg::t_avg        n_avg;
    hsrd_pkg::t_yaw_plus   n_ref;
    hsrd_pkg::t_dir        n_dir;
    logic [3:0]            n_swings;
    logic [31:0]           n_wstart;
    logic [7:0]            n_warm;
    logic                  n_have;
    logic signed [16:0]    n_off_roll;
    logic signed [16:0]    n_off_pitch;
    logic signed [16:0]    n_off_yaw;

    logic                  r_out_valid;
    hsrd_pkg::t_status     r_o_status;
    logic signed [16:0]    r_o_roll;
    logic signed [16:0]    r_o_pitch;
    logic signed [16:0]    r_o_yaw;
    logic signed [16:0]    r_o_off_roll;
    logic signed [16:0]    r_o_off_pitch;
    logic signed [16:0]    r_o_off_yaw;
    logic                  r_o_have;
    logic [3:0]            r_o_swings;
    logic                  r_o_recentered;
    logic [17:0]           r_o_avg;

    logic                  w_accept;
    logic                  w_adv;
    logic signed [16:0]    w_yaw_neg;
    hsrd_pkg::t_yaw_plus   w_yaw_plus;
    hsrd_pkg::t_yaw_plus   w_avg_int;
    logic [31:0]           w_elapsed;
    logic signed [18:0]    w_diff;
    logic [18:0]           w_mag;
    logic                  w_diff_pos;
    logic                  w_diff_neg;
    hsrd_pkg::t_status     w_status;
    logic                  w_show;
    logic                  w_recenter;
    logic                  w_filter_en;
    hsrd_pkg::t_avg        w_avg_sel;
    hsrd_pkg::t_avg        w_avg_next;

    // Transaction handshake: the input register drains whenever the result register
    // is empty or being taken.
    assign w_adv    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall  = r_in_valid && r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imu_enabled        <= hsrd_pkg::IMU_ENABLED_RST;
            r_swing_threshold    <= hsrd_pkg::SWING_THRESHOLD_RST;
            r_timeout_ms         <= hsrd_pkg::TIMEOUT_MS_RST;
            r_swings_to_recenter <= hsrd_pkg::SWINGS_TO_RECENTER_RST;
            r_recenter_skip      <= hsrd_pkg::RECENTER_SKIP_RST;
        end else if (i_cfg_we) begin
            unique case (hsrd_pkg::t_cfg_idx'(i_cfg_index))
                hsrd_pkg::CFG_IMU_ENABLED:        r_imu_enabled        <= i_cfg_data[0];
                hsrd_pkg::CFG_SWING_THRESHOLD:    r_swing_threshold    <= i_cfg_data;
                hsrd_pkg::CFG_TIMEOUT_MS:         r_timeout_ms         <= i_cfg_data;
                hsrd_pkg::CFG_SWINGS_TO_RECENTER: r_swings_to_recenter <= i_cfg_data[3:0];
                hsrd_pkg::CFG_RECENTER_SKIP:      r_recenter_skip      <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_roll  <= i_roll_angle;
            r_in_pitch <= i_pitch_angle;
            r_in_yaw   <= i_yaw_angle;
            r_in_len   <= i_packet_length;
            r_in_time  <= i_time_ms;
        end
    end

    assign w_yaw_neg  = (r_in_yaw == hsrd_pkg::ANGLE_MIN) ? hsrd_pkg::ANGLE_MAX : -r_in_yaw;
    assign w_yaw_plus = {w_yaw_neg[16], w_yaw_neg} + hsrd_pkg::YAW_BIAS;
    assign w_avg_int  = r_avg[hsrd_pkg::AVG_FRACTION_BITS +: hsrd_pkg::YAW_PLUS_W];
    assign w_elapsed  = r_in_time - r_wstart;

    always_comb begin
        n_ref       = r_ref;
        n_dir       = r_dir;
        n_swings    = r_swings;
        n_wstart    = r_wstart;
        n_warm      = r_warm;
        n_have      = r_have;
        n_off_roll  = r_off_roll;
        n_off_pitch = r_off_pitch;
        n_off_yaw   = r_off_yaw;
        w_status    = hsrd_pkg::ST_DROPPED;
        w_show      = 1'b0;
        w_recenter  = 1'b0;
        w_filter_en = 1'b0;
        w_avg_sel   = r_avg;
        w_diff      = '0;
        w_mag       = '0;
        w_diff_pos  = 1'b0;
        w_diff_neg  = 1'b0;
        priority if (r_in_len < hsrd_pkg::MIN_PACKET) begin
            w_status = hsrd_pkg::ST_DROPPED;
        end else if (r_imu_enabled && !r_have && (r_warm != 8'd0)) begin
            n_warm   = r_warm - 8'd1;
            w_status = hsrd_pkg::ST_SKIPPED;
        end else begin
            w_status    = hsrd_pkg::ST_TRACKED;
            w_show      = 1'b1;
            w_filter_en = 1'b1;
            if (r_imu_enabled && !r_have) begin
                n_off_roll  = r_in_roll;
                n_off_pitch = r_in_pitch;
                n_off_yaw   = w_yaw_neg;
                n_have      = 1'b1;
            end
            if (w_elapsed > {16'd0, r_timeout_ms}) begin
                n_swings = 4'd0;
                n_dir    = hsrd_pkg::DIR_NONE;
                n_wstart = r_in_time;
            end
            if (n_swings == 4'd0) begin
                n_ref = w_avg_int;
            end
            w_diff     = $signed({1'b0, w_yaw_plus}) - $signed({1'b0, n_ref});
            w_mag      = w_diff[18] ? 19'(-w_diff) : 19'(w_diff);
            w_diff_neg = w_diff[18];
            w_diff_pos = !w_diff[18] && (w_diff != 19'sd0);
            if (w_mag > {3'd0, r_swing_threshold}) begin
                priority if (n_dir == hsrd_pkg::DIR_NONE) begin
                    n_dir = w_diff_pos ? hsrd_pkg::DIR_POS : hsrd_pkg::DIR_NEG;
                end else if ((w_diff_pos && (n_dir == hsrd_pkg::DIR_POS)) ||
                             (w_diff_neg && (n_dir == hsrd_pkg::DIR_NEG))) begin
                    n_dir    = (n_dir == hsrd_pkg::DIR_POS) ? hsrd_pkg::DIR_NEG
                                                            : hsrd_pkg::DIR_POS;
                    n_ref    = w_yaw_plus;
                    n_swings = n_swings + 4'd1;
                end else begin
                end
            end
            if (n_swings >= r_swings_to_recenter) begin
                w_avg_sel  = {w_yaw_plus, {hsrd_pkg::AVG_FRACTION_BITS{1'b0}}};
                n_swings   = 4'd0;
                n_dir      = hsrd_pkg::DIR_NONE;
                n_have     = 1'b0;
                n_wstart   = r_in_time;
                n_warm     = r_recenter_skip;
                w_recenter = 1'b1;
            end
        end
    end

    hsrd_filter u_filter (
        .i_yaw_plus (w_yaw_plus),
        .i_avg      (w_avg_sel),
        .o_avg_next (w_avg_next)
    );

    assign n_avg = w_filter_en ? w_avg_next : r_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg       <= '0;
            r_ref       <= '0;
            r_dir       <= hsrd_pkg::DIR_NONE;
            r_swings    <= 4'd0;
            r_wstart    <= 32'd0;
            r_warm      <= hsrd_pkg::STARTUP_SKIP_RST;
            r_have      <= 1'b0;
            r_off_roll  <= 17'sd0;
            r_off_pitch <= 17'sd0;
            r_off_yaw   <= 17'sd0;
        end else if (w_adv) begin
            r_avg       <= n_avg;
            r_ref       <= n_ref;
            r_dir       <= n_dir;
            r_swings    <= n_swings;
            r_wstart    <= n_wstart;
            r_warm      <= n_warm;
            r_have      <= n_have;
            r_off_roll  <= n_off_roll;
            r_off_pitch <= n_off_pitch;
            r_off_yaw   <= n_off_yaw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_status     <= w_status;
            r_o_roll       <= w_show ? r_in_roll : 17'sd0;
            r_o_pitch      <= w_show ? r_in_pitch : 17'sd0;
            r_o_yaw        <= w_show ? w_yaw_neg : 17'sd0;
            r_o_off_roll   <= n_off_roll;
            r_o_off_pitch  <= n_off_pitch;
            r_o_off_yaw    <= n_off_yaw;
            r_o_have       <= n_have;
            r_o_swings     <= n_swings;
            r_o_recentered <= w_recenter;
            r_o_avg        <= n_avg[hsrd_pkg::AVG_FRACTION_BITS +: hsrd_pkg::YAW_PLUS_W];
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_o_status;
    assign o_roll_out         = r_o_roll;
    assign o_pitch_out        = r_o_pitch;
    assign o_yaw_out          = r_o_yaw;
    assign o_roll_offset_out  = r_o_off_roll;
    assign o_pitch_offset_out = r_o_off_pitch;
    assign o_yaw_offset_out   = r_o_off_yaw;
    assign o_offsets_valid    = r_o_have;
    assign o_swing_count      = r_o_swings;
    assign o_recentered       = r_o_recentered;
    assign o_average_yaw_out  = r_o_avg;

    // A recenter clears the swing window and drops the offsets in the same result.
    `ASSERT_IMPLIES(a_recenter_clears, i_clk, i_rst_n, o_valid && o_recentered, o_swing_count == 4'd0 && !o_offsets_valid && o_status == hsrd_pkg::ST_TRACKED)
    // Only tracked samples show angles or trigger a recenter.
    `ASSERT_IMPLIES(a_untracked_quiet, i_clk, i_rst_n, o_valid && o_status != hsrd_pkg::ST_TRACKED, !o_recentered && o_roll_out == 17'sd0 && o_yaw_out == 17'sd0)
    // The detector state moves only when a transaction passes to the result register.
    `ASSERT_NEXT(a_state_holds, i_clk, i_rst_n, !w_adv, $stable(r_swings) && $stable(r_avg) && $stable(r_warm))
    // A held result with a full input register keeps the input register full.
    `ASSERT_NEXT(a_input_held, i_clk, i_rst_n, r_in_valid && r_out_valid && i_stall, r_in_valid)
    // Every result leaves through the result register before the next one is loaded.
    `ASSERT_NEXT(a_result_kept, i_clk, i_rst_n, o_valid && i_stall, o_valid)

endmodule

/* rtl/hsrd_filter.sv */
// One-pole low-pass update of the fixed-point yaw average with round-half-up.
module hsrd_filter (
    input  hsrd_pkg::t_yaw_plus i_yaw_plus,
    input  hsrd_pkg::t_avg      i_avg,
    output hsrd_pkg::t_avg      o_avg_next
);

    hsrd_pkg::t_sum w_keep;
    hsrd_pkg::t_sum w_feed;
    hsrd_pkg::t_sum w_sum;

    assign w_keep = hsrd_pkg::t_sum'(i_avg) * hsrd_pkg::t_sum'(hsrd_pkg::KEEP_GAIN);
    assign w_feed = hsrd_pkg::t_sum'({i_yaw_plus, {hsrd_pkg::AVG_FRACTION_BITS{1'b0}}})
                  * hsrd_pkg::t_sum'(hsrd_pkg::FILTER_GAIN);
    assign w_sum  = w_keep + w_feed + hsrd_pkg::t_sum'(hsrd_pkg::ROUND_HALF);

    assign o_avg_next = w_sum[hsrd_pkg::GAIN_SHIFT +: hsrd_pkg::AVG_W];

endmodule
